>>> src/ipw_pkg.sv
// Shared types and constants for the image packet page write planner.
// No dependencies; used by the controller, the datapath and the top level.
package ipw_pkg;

  localparam int PACKET_BYTES_DEF = 128;
  localparam int FRAME_COUNT_DEF  = 4;

  localparam int FRAME_SHIFT = 10;   // 1024-byte frames
  localparam int PAGE_SHIFT  = 7;    // 128 columns per page
  localparam int PAGE_COLS   = 128;
  localparam int ADDR_W      = 12;

  localparam logic [1:0] KIND_PAGE    = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_RANGE   = 2'd2;
  localparam logic [1:0] KIND_MISSING = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       calc_offset;
    logic       clear_high;
    logic       set_high;
    logic       start_walk;
    logic       step_walk;
    logic       load_out;
    logic [1:0] out_kind;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic act_clear;
    logic out_of_range;
    logic retrans;
    logic zero_len;
    logic walk_missing;
    logic walk_last;
    logic out_free;
  } status_t;

endpackage

>>> src/image_packet_page_write_planner.sv
// Image packet page write planner: top level joining controller and datapath.
// Depends on ipw_pkg, ipw_ctrl and ipw_datapath.
//
// Input stream (s_axis): one word per packet or clear request. tuser = 1 clears
// the highest seen index and gives no result. Otherwise the packet is placed at
// index * PACKET_BYTES in a store of 1024-byte frames and display writes follow.
// Output stream (m_axis): one word per command; tuser carries the kind, tlast
// marks the last command of a packet. Kinds: page write, full frame write
// (retransmission), frame out of range, next frame missing (second part of a
// frame-crossing packet dropped).
// A packet of zero length that is in range and no retransmission updates the
// highest index and gives no word. Sequence: accept, the offset multiply,
// classification, then each command in turn into the output register (at most 2
// commands at the default packet size, at most 3 for any). A clear returns to
// idle from the multiply state, a zero-length packet from classification.
// The page walk emits one command per cycle while the output register is free.
// s_axis_tready is high only while the controller is idle, and a command waiting
// in the output register does not block accepting the next item.
// A stall on m_axis_tready holds the output word and pauses the walk.
// Reset (rst, synchronous) clears the highest index and empties the output.
module image_packet_page_write_planner
  import ipw_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int FRAME_COUNT  = FRAME_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // packet_index[15:0], packet_length[23:16]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // page[2:0], start_column[9:3],
                                      // column_count[17:10], source_address[29:18]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast    // last
);

  cmd_t    cmd;
  status_t status;

  ipw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ipw_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .FRAME_COUNT  (FRAME_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_action (s_axis_tuser),
    .in_index  (s_axis_tdata[15:0]),
    .in_length (s_axis_tdata[23:16]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  a_page_fits: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_PAGE) |->
      ({1'b0, m_axis_tdata[9:3]} + m_axis_tdata[17:10] <= 9'(PAGE_COLS)
       && m_axis_tdata[17:10] != 8'd0))
    else $error("page write runs past the page end or is empty");

  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_PAGE) |-> m_axis_tlast)
    else $error("full frame or error word not marked last");

  a_full_frame: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_FULL) |->
      (m_axis_tdata[17:10] == 8'(PAGE_COLS) && m_axis_tdata[27:18] == 10'd0))
    else $error("full frame write not frame aligned");

endmodule

>>> src/ipw_ctrl.sv
// Controller state machine for the page write planner.
// Depends on ipw_pkg; drives the datapath through cmd_t, reads status_t.
module ipw_ctrl
  import ipw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_FLAG  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] flag_kind, flag_kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flag_kind <= KIND_RANGE;
    end else begin
      state     <= state_next;
      flag_kind <= flag_kind_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    flag_kind_next = flag_kind;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        if (status.act_clear) begin
          cmd.clear_high = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.calc_offset = 1'b1;
          state_next      = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (status.out_of_range) begin
          flag_kind_next = KIND_RANGE;
          state_next     = S_FLAG;
        end else if (status.retrans) begin
          flag_kind_next = KIND_FULL;
          state_next     = S_FLAG;
        end else begin
          cmd.set_high   = 1'b1;
          cmd.start_walk = 1'b1;
          state_next     = status.zero_len ? S_IDLE : S_EMIT;
        end
      end
      S_FLAG: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = flag_kind;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.walk_missing) begin
            cmd.out_kind = KIND_MISSING;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.out_kind  = KIND_PAGE;
            cmd.out_last  = status.walk_last;
            cmd.step_walk = 1'b1;
            if (status.walk_last) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/ipw_datapath.sv
// Datapath: item registers, offset multiply, highest index, page walk, output register.
// Depends on ipw_pkg; controlled by ipw_ctrl through cmd_t and status_t.
module ipw_datapath
  import ipw_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int FRAME_COUNT  = FRAME_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_action,
  input  logic [15:0] in_index,
  input  logic [7:0]  in_length,
  input  cmd_t        cmd,
  output status_t     status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data,
  output logic [1:0]  out_kind,
  output logic        out_last
);

  localparam int PB_W    = $clog2(PACKET_BYTES + 1);
  localparam int OFS_W   = 16 + PB_W;
  localparam int WALK_W  = OFS_W + 1;
  localparam int FRAME_W = WALK_W - FRAME_SHIFT;

  logic              act_r;
  logic [15:0]       idx_r;
  logic [7:0]        len_r;
  logic [OFS_W-1:0]  offset_r;
  logic [15:0]       highest;
  logic [WALK_W-1:0] wofs;
  logic [7:0]        rem;

  logic [FRAME_W-1:0] start_frame;
  logic [FRAME_W-1:0] walk_frame;
  logic [7:0]         cols_left;
  logic [7:0]         chunk;

  logic [1:0]        kind_q;
  logic [2:0]        page_q;
  logic [6:0]        col_q;
  logic [7:0]        count_q;
  logic [ADDR_W-1:0] addr_q;

  assign start_frame = FRAME_W'(offset_r >> FRAME_SHIFT);
  assign walk_frame  = wofs[WALK_W-1:FRAME_SHIFT];
  assign cols_left   = 8'(PAGE_COLS) - {1'b0, wofs[PAGE_SHIFT-1:0]};
  assign chunk       = (cols_left < rem) ? cols_left : rem;

  assign status.act_clear    = act_r;
  assign status.out_of_range = (start_frame >= FRAME_W'(FRAME_COUNT));
  assign status.retrans      = (highest > idx_r);
  assign status.zero_len     = (len_r == 8'd0);
  assign status.walk_missing = (walk_frame >= FRAME_W'(FRAME_COUNT));
  assign status.walk_last    = (chunk == rem);
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      idx_r <= in_index;
      len_r <= in_length;
    end
    if (cmd.calc_offset) begin
      offset_r <= OFS_W'(idx_r) * OFS_W'(PACKET_BYTES);
    end
    if (cmd.start_walk) begin
      wofs <= {1'b0, offset_r};
      rem  <= len_r;
    end else if (cmd.step_walk) begin
      wofs <= wofs + WALK_W'(chunk);
      rem  <= rem - chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '0;
    end else if (cmd.clear_high) begin
      highest <= '0;
    end else if (cmd.set_high) begin
      highest <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind_q   <= cmd.out_kind;
      out_last <= cmd.out_last;
      unique case (cmd.out_kind)
        KIND_PAGE: begin
          page_q  <= wofs[FRAME_SHIFT-1:PAGE_SHIFT];
          col_q   <= wofs[PAGE_SHIFT-1:0];
          count_q <= chunk;
          addr_q  <= wofs[ADDR_W-1:0];
        end
        KIND_FULL: begin
          page_q  <= '0;
          col_q   <= '0;
          count_q <= 8'(PAGE_COLS);
          addr_q  <= {offset_r[ADDR_W-1:FRAME_SHIFT], {FRAME_SHIFT{1'b0}}};
        end
        default: begin
          page_q  <= '0;
          col_q   <= '0;
          count_q <= '0;
          addr_q  <= '0;
        end
      endcase
    end
  end

  assign out_data = {2'b00, addr_q, count_q, col_q, page_q};
  assign out_kind = kind_q;

endmodule

>>> sim/page_write_checker.sv
// Watches both streams of the page write planner, predicts the display write
// commands of each accepted word and compares them field by field.
// Depends on ipw_pkg for kinds and page geometry.
module page_write_checker
  import ipw_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int FRAME_COUNT  = FRAME_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // packet_index[15:0], packet_length[23:16]
  input  logic        s_axis_tuser,   // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // page[2:0], start_column[9:3],
                                      // column_count[17:10], source_address[29:18]
  input  logic [1:0]  m_axis_tuser,   // kind[1:0]
  input  logic        m_axis_tlast,   // last
  output int          mismatches,
  output int          writes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES = 1024;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  page;
    logic [6:0]  start_column;
    logic [7:0]  column_count;
    logic [11:0] source_address;
    logic        last;
  } page_cmd_t;

  page_cmd_t   planned_writes[$];
  logic [15:0] highest_seen;

  function automatic page_cmd_t flag_cmd(input logic [1:0] kind);
    page_cmd_t c;
    c = '0;
    c.kind = kind;
    return c;
  endfunction

  task automatic push_pages(input int base, input int pos, input int len);
    int first_page, last_page, end_pos, done, cs, ce;
    page_cmd_t c;
    if (len == 0) return;
    end_pos = pos + len - 1;
    first_page = pos / PAGE_COLS;
    last_page = end_pos / PAGE_COLS;
    done = 0;
    for (int p = first_page; p <= last_page; p++) begin
      cs = (p == first_page) ? pos % PAGE_COLS : 0;
      ce = (p == last_page) ? end_pos % PAGE_COLS : PAGE_COLS - 1;
      c.kind = KIND_PAGE;
      c.page = 3'(p);
      c.start_column = 7'(cs);
      c.column_count = 8'(ce - cs + 1);
      c.source_address = 12'(base + pos + done);
      c.last = 1'b0;
      planned_writes.push_back(c);
      done += ce - cs + 1;
    end
  endtask

  task automatic plan_writes(input logic act, input logic [15:0] idx,
                             input logic [7:0] len);
    int offset, frame, pos, base, head, before_cnt;
    page_cmd_t c;
    before_cnt = planned_writes.size();
    if (act) begin
      highest_seen = '0;
      return;
    end
    offset = int'(idx) * PACKET_BYTES;
    frame = offset / FRAME_BYTES;
    pos = offset % FRAME_BYTES;
    base = frame * FRAME_BYTES;
    if (frame >= FRAME_COUNT) begin
      planned_writes.push_back(flag_cmd(KIND_RANGE));
    end else if (highest_seen > idx) begin
      c = flag_cmd(KIND_FULL);
      c.column_count = 8'(PAGE_COLS);
      c.source_address = 12'(base);
      planned_writes.push_back(c);
    end else begin
      highest_seen = idx;
      if (pos + int'(len) > FRAME_BYTES) begin
        head = FRAME_BYTES - pos;
        push_pages(base, pos, head);
        if (frame + 1 < FRAME_COUNT) push_pages(base + FRAME_BYTES, 0, int'(len) - head);
        else planned_writes.push_back(flag_cmd(KIND_MISSING));
      end else begin
        push_pages(base, pos, int'(len));
      end
    end
    if (planned_writes.size() > before_cnt) begin
      c = planned_writes.pop_back();
      c.last = 1'b1;
      planned_writes.push_back(c);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    page_cmd_t got, want;
    if (rst) begin
      planned_writes.delete();
      highest_seen = '0;
      mismatches = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        plan_writes(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.page = m_axis_tdata[2:0];
        got.start_column = m_axis_tdata[9:3];
        got.column_count = m_axis_tdata[17:10];
        got.source_address = m_axis_tdata[29:18];
        got.last = m_axis_tlast;
        if (planned_writes.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual tdata %h tuser %0d last %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = planned_writes.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("page", want.page, got.page);
          check_field("start_column", want.start_column, got.start_column);
          check_field("column_count", want.column_count, got.column_count);
          check_field("source_address", want.source_address, got.source_address);
          check_field("last", want.last, got.last);
        end
      end
    end
    writes_pending = planned_writes.size();
  end

endmodule

>>> sim/image_packet_page_write_planner_test.sv
// Stimulus and verdict for the image packet page write planner.
// Depends on the planner RTL, ipw_pkg and page_write_checker.
module image_packet_page_write_planner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_ITEMS   = 40;
  localparam int TAIL_CYCLES  = 20;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic hold_req;
  bit   calm;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   mismatches;
  int   writes_pending;
  int   cycles;

  image_packet_page_write_planner dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  page_write_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .writes_pending(writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // sink side: random stalls, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic act, input logic [15:0] idx, input logic [7:0] len);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {len, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (!calm && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (writes_pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 8'd0;
    if (r < 30) return 8'($urandom_range(129, 255));
    return 8'($urandom_range(1, 128));
  endfunction

  initial begin
    logic        act;
    logic [15:0] idx;
    logic [7:0]  len;
    int          pick;
    int          cursor;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    hold_req <= 1'b0;
    calm = 1'b0;
    src_idle_pct = 25;
    sink_idle_pct = 25;
    cursor = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(1'b1, 16'hFFFF, 8'hFF);    // clear, packet fields ignored
    offer(1'b0, 16'd0, 8'd1);
    offer(1'b0, 16'd0, 8'd128);      // equal index is not a retransmission
    offer(1'b0, 16'd3, 8'd255);      // two pages
    offer(1'b0, 16'd7, 8'd255);      // frame crossing
    offer(1'b0, 16'd5, 8'd10);       // retransmission
    offer(1'b0, 16'd7, 8'd0);        // zero length
    offer(1'b0, 16'd8, 8'd0);
    offer(1'b0, 16'd9, 8'd128);
    offer(1'b0, 16'd15, 8'd129);
    offer(1'b0, 16'd23, 8'd255);
    offer(1'b0, 16'd31, 8'd200);     // next frame missing
    offer(1'b0, 16'd31, 8'd128);
    offer(1'b0, 16'd30, 8'd64);
    offer(1'b0, 16'd32, 8'd1);       // frame out of range
    offer(1'b0, 16'hFFFF, 8'd255);
    offer(1'b0, 16'h8000, 8'd0);
    offer(1'b1, 16'd0, 8'd0);
    offer(1'b0, 16'd4, 8'd255);
    offer(1'b0, 16'd0, 8'd1);
    offer(1'b0, 16'd31, 8'd255);
    offer(1'b1, 16'h5A5A, 8'hA5);
    offer(1'b0, 16'd24, 8'd128);
    wait_drained;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        src_idle_pct = $urandom_range(0, 1) ? 30 : 0;
        sink_idle_pct = $urandom_range(0, 1) ? 30 : 0;
      end
      if (i == 100) hold_req <= 1'b1;
      if (i == 170) wait_drained;
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 99);
      act = 1'b0;
      len = pick_length();
      if (pick < 5 || (cursor >= 30 && pick < 20)) begin
        act = 1'b1;
        idx = 16'($urandom);
        len = 8'($urandom);
        cursor = 0;
      end else if (pick < 13) begin
        idx = 16'($urandom);
        len = 8'($urandom);
      end else if (pick < 23) begin
        idx = 16'($urandom_range(0, cursor));
      end else if (pick < 28) begin
        idx = 16'($urandom_range(32, 47));
      end else begin
        idx = 16'(cursor + $urandom_range(0, 2));
        if (idx < 32) cursor = idx;
      end
      offer(act, idx, len);
    end

    wait_drained;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && writes_pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
src/ipw_pkg.sv
src/ipw_ctrl.sv
src/ipw_datapath.sv
src/image_packet_page_write_planner.sv
sim/page_write_checker.sv
sim/image_packet_page_write_planner_test.sv
